// ===== hdl/pci_pkg.sv =====
`timescale 1ns / 1ps

package pci_pkg;

  // Field widths of the item channels and the register file
  localparam int SAMPLE_W  = 14;
  localparam int BCOUNT_W  = 11;
  localparam int GSTART_W  = 12;
  localparam int GSTOP_W   = 13;
  localparam int CHARGE_W  = 36;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Largest baseline window that counts as a valid setup
  localparam logic [BCOUNT_W-1:0] BASELINE_MAX = BCOUNT_W'(1024);

  // Charge accumulator saturates here
  localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};

  // Register reset values
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = BCOUNT_W'(200);
  localparam logic [GSTART_W-1:0] GSTART_RST = GSTART_W'(400);
  localparam logic [GSTOP_W-1:0]  GSTOP_RST  = GSTOP_W'(900);

  // Register index codes (byte address / 4)
  localparam logic [1:0] REG_BASELINE_COUNT = 2'd0;
  localparam logic [1:0] REG_GATE_START     = 2'd1;
  localparam logic [1:0] REG_GATE_STOP      = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                record_end;
  } in_item_t;

  typedef struct packed {
    logic [CHARGE_W-1:0] scaled_charge;
    logic                short_record;
  } out_item_t;

  typedef struct packed {
    logic [BCOUNT_W-1:0] baseline_count;
    logic [GSTART_W-1:0] gate_start;
    logic [GSTOP_W-1:0]  gate_stop;
  } cfg_t;

endpackage

// ===== hdl/pci_regs.sv =====
`timescale 1ns / 1ps

module pci_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [pci_pkg::PADDR_W-1:0] paddr,
  input  logic [pci_pkg::PDATA_W-1:0] pwdata,
  output logic [pci_pkg::PDATA_W-1:0] prdata,
  output logic                    pready,
  output pci_pkg::cfg_t           cfg
);
  import pci_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Register writes; addresses past the last register are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline_count <= BCOUNT_RST;
      cfg_r.gate_start     <= GSTART_RST;
      cfg_r.gate_stop      <= GSTOP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASELINE_COUNT: cfg_r.baseline_count <= pwdata[BCOUNT_W-1:0];
        REG_GATE_START:     cfg_r.gate_start     <= pwdata[GSTART_W-1:0];
        REG_GATE_STOP:      cfg_r.gate_stop      <= pwdata[GSTOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_BASELINE_COUNT: prdata = PDATA_W'(cfg_r.baseline_count);
      REG_GATE_START:     prdata = PDATA_W'(cfg_r.gate_start);
      REG_GATE_STOP:      prdata = PDATA_W'(cfg_r.gate_stop);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hdl/pulse_charge_integrator.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+-----------------------------
// input    | in_valid, in_stall, in_data             | one sample item per accept
// result   | out_valid, out_stall, out_data          | one charge item per record
// config   | psel, penable, pwrite, paddr, pwdata,   | baseline_count @0x0,
//          | prdata, pready                          | gate_start @0x4, gate_stop @0x8
//
// One sample item is taken every clock while in_stall is low. Three register
// stages: input register, product/baseline stage, result register; a record_end
// item reaches the result register through the product/baseline stage. The charge
// accumulator update (abs diff plus saturating add) sets the per-sample cycle.
// Reset (rst_n low, synchronous) empties the pipe, clears the record state and
// loads the register defaults. out_stall holds the result register; items keep
// flowing until a second record_end reaches the stage behind it.

module pulse_charge_integrator #(
  parameter int MAX_RECORD  = 4096,
  parameter int SAMPLE_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pci_pkg::PADDR_W-1:0] paddr,
  input  logic [pci_pkg::PDATA_W-1:0] pwdata,
  output logic [pci_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pci_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pci_pkg::out_item_t          out_data
);
  import pci_pkg::*;

  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int IW = $clog2(MAX_RECORD + 1);
  localparam int CW = (IW > GSTOP_W) ? IW : GSTOP_W;
  localparam int BW = SW + BCOUNT_W;

  cfg_t cfg;

  pci_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline registers
  logic            a_v_r, a_last_r;
  logic [SW-1:0]   a_s_r;
  logic [IW-1:0]   idx_r;
  logic [BW-1:0]   bsum_r;
  logic            b_v_r, b_last_r, b_gate_r, b_short_r;
  logic [BW-1:0]   b_bsum_r, b_prod_r;
  logic [CHARGE_W-1:0] acc_r;
  logic            out_v_r;
  out_item_t       out_r;

  logic out_free, b_adv, a_adv, in_acc, a_go, b_go;

  // Flow control
  assign out_free = !out_v_r || !out_stall;
  assign b_adv    = !b_v_r || !b_last_r || out_free;
  assign a_adv    = !a_v_r || b_adv;
  assign in_stall = !a_adv;
  assign in_acc   = in_valid && !in_stall;
  assign a_go     = a_v_r && a_adv;
  assign b_go     = b_v_r && b_adv;

  // Stage A: index windows, baseline sum, product
  logic [CW-1:0] idx_c;
  logic          active, in_base, in_gate, setup_bad, too_short;
  logic [IW-1:0] idx_nxt;
  logic [BW-1:0] bsum_nxt, prod_nxt;

  always_comb begin
    idx_c     = CW'(idx_r);
    active    = idx_r < IW'(MAX_RECORD);
    in_base   = active && (idx_c < CW'(cfg.baseline_count));
    in_gate   = active && (idx_c >= CW'(cfg.gate_start)) && (idx_c < CW'(cfg.gate_stop));
    bsum_nxt  = bsum_r + (in_base ? BW'(a_s_r) : '0);
    idx_nxt   = active ? idx_r + 1'b1 : idx_r;
    prod_nxt  = BW'(cfg.baseline_count) * BW'(a_s_r);
    setup_bad = (cfg.baseline_count == '0) || (cfg.baseline_count > BASELINE_MAX) ||
                (cfg.gate_start < GSTART_W'(cfg.baseline_count));
    too_short = CW'(idx_nxt) < CW'(cfg.gate_stop);
  end

  // Stage B: abs difference and saturating accumulate
  logic [BW-1:0]       diff;
  logic [CHARGE_W:0]   acc_sum;
  logic [CHARGE_W-1:0] acc_nxt;

  always_comb begin
    diff    = (b_bsum_r >= b_prod_r) ? (b_bsum_r - b_prod_r) : (b_prod_r - b_bsum_r);
    acc_sum = {1'b0, acc_r} + (b_gate_r ? (CHARGE_W + 1)'(diff) : '0);
    acc_nxt = acc_sum[CHARGE_W] ? CHARGE_MAX : acc_sum[CHARGE_W-1:0];
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_adv) begin
      a_v_r <= in_acc;
    end
    if (in_acc) begin
      a_s_r    <= in_data.sample_value[SW-1:0];
      a_last_r <= in_data.record_end;
    end
  end

  // Per-record index and baseline state, cleared at record end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      bsum_r <= '0;
    end else if (a_go) begin
      idx_r  <= a_last_r ? '0 : idx_nxt;
      bsum_r <= a_last_r ? '0 : bsum_nxt;
    end
  end

  // Stage B register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_adv) begin
      b_v_r <= a_v_r;
    end
    if (a_go) begin
      b_bsum_r  <= bsum_nxt;
      b_prod_r  <= prod_nxt;
      b_gate_r  <= in_gate;
      b_last_r  <= a_last_r;
      b_short_r <= setup_bad || too_short;
    end
  end

  // Charge accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (b_go) begin
      acc_r <= b_last_r ? '0 : acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= b_go && b_last_r;
    end
    if (b_go && b_last_r) begin
      out_r.scaled_charge <= acc_nxt;
      out_r.short_record  <= b_short_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/pci_checker.sv =====
`timescale 1ns / 1ps

module pci_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               pready,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pci_pkg::out_item_t out_data
);
  import pci_pkg::*;

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Register port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind pulse_charge_integrator pci_checker u_pci_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .pready    (pready),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/pulse_charge_integrator_test.sv =====
`timescale 1ns / 1ps

module pulse_charge_integrator_test;
  import pci_pkg::*;

  localparam int RECORD_MAX    = 4096;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_ITEMS  = 1280;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  // Sample styles for generated records
  typedef enum int {
    STYLE_UNIFORM,
    STYLE_RAILS,
    STYLE_PULSE,
    STYLE_BITS
  } sample_style_e;

  logic clk;
  logic rst_n = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pulse_charge_integrator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Items waiting for the driver, and charges waiting for the result port
  in_item_t  pending_samples[$];
  out_item_t expected_charges[$];

  int samples_queued   = 0;
  int samples_accepted = 0;
  int records_checked  = 0;
  int settings_count   = 0;
  int stalled_offers   = 0;
  int mismatches       = 0;
  int cycle_count      = 0;
  int hold_at          = 32'h7fffffff;
  bit quiet            = 1'b0;

  // Predictor state: register copy plus per-record accumulators
  cfg_t            gate_cfg = '{BCOUNT_RST, GSTART_RST, GSTOP_RST};
  int              rec_index  = 0;
  longint unsigned base_sum   = 0;
  longint unsigned charge_sum = 0;

  function automatic void integrate_sample(input in_item_t item);
    longint unsigned s;
    longint unsigned scaled;
    longint unsigned diff;
    out_item_t       res;
    s = item.sample_value;
    // samples past the record limit are dropped
    if (rec_index < RECORD_MAX) begin
      if (rec_index < gate_cfg.baseline_count) base_sum += s;
      if (rec_index >= gate_cfg.gate_start && rec_index < gate_cfg.gate_stop) begin
        scaled = longint'(gate_cfg.baseline_count) * s;
        diff = (base_sum >= scaled) ? base_sum - scaled : scaled - base_sum;
        charge_sum += diff;
        if (charge_sum > CHARGE_MAX) charge_sum = CHARGE_MAX;
      end
      rec_index++;
    end
    if (item.record_end) begin
      res.scaled_charge = charge_sum[CHARGE_W-1:0];
      res.short_record  = (gate_cfg.baseline_count == 0) ||
                          (gate_cfg.baseline_count > BASELINE_MAX) ||
                          (gate_cfg.gate_start < gate_cfg.baseline_count) ||
                          (rec_index < gate_cfg.gate_stop);
      expected_charges.insert(expected_charges.size(), res);
      rec_index  = 0;
      base_sum   = 0;
      charge_sum = 0;
    end
  endfunction

  // Driver: one item per accept, random idle bursts, calm stretches
  int send_gap  = 0;
  bit send_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) begin
        // hold the offered item
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet && !send_calm && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 9);
      end else if (pending_samples.size() > 0) begin
        in_data  <= pending_samples.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) send_calm <= !send_calm;
    end
  end

  // Receiver: random stall bursts and one long hold-off to back up the pipe
  int stall_gap  = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  bit recv_calm  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && samples_accepted >= hold_at) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        out_stall <= 1'b1;
        stall_gap <= stall_gap - 1;
      end else if (!quiet && !recv_calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_gap <= $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) recv_calm <= !recv_calm;
    end
  end

  // Monitor: predict on every accepted sample, check every accepted result
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n) begin
      if (in_valid && in_stall) stalled_offers++;
      if (in_valid && !in_stall) begin
        samples_accepted++;
        integrate_sample(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_charges.size() == 0) begin
          $error("result item with no record pending: scaled_charge %0d short_record %0d",
                 out_data.scaled_charge, out_data.short_record);
          mismatches++;
        end else begin
          exp_res = expected_charges.pop_front();
          records_checked++;
          if (out_data.scaled_charge !== exp_res.scaled_charge) begin
            $error("scaled_charge: expected %0d, got %0d",
                   exp_res.scaled_charge, out_data.scaled_charge);
            mismatches++;
          end
          if (out_data.short_record !== exp_res.short_record) begin
            $error("short_record: expected %0d, got %0d",
                   exp_res.short_record, out_data.short_record);
            mismatches++;
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Register write followed by a read-back of the same register
  task automatic write_register(input logic [1:0] idx, input int unsigned value);
    logic [PDATA_W-1:0] readback;
    logic [PDATA_W-1:0] want;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_BASELINE_COUNT: gate_cfg.baseline_count = value[BCOUNT_W-1:0];
      REG_GATE_START:     gate_cfg.gate_start     = value[GSTART_W-1:0];
      REG_GATE_STOP:      gate_cfg.gate_stop      = value[GSTOP_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BASELINE_COUNT: want = PDATA_W'(gate_cfg.baseline_count);
      REG_GATE_START:     want = PDATA_W'(gate_cfg.gate_start);
      default:            want = PDATA_W'(gate_cfg.gate_stop);
    endcase
    if (readback !== want) begin
      $error("register %0d readback: expected %0d, got %0d", idx, want, readback);
      mismatches++;
    end
  endtask

  task automatic set_gate(input int unsigned bcount, input int unsigned gstart,
                          input int unsigned gstop);
    write_register(REG_BASELINE_COUNT, bcount);
    write_register(REG_GATE_START, gstart);
    write_register(REG_GATE_STOP, gstop);
    settings_count++;
  endtask

  // Everything accepted, every result seen, then a settling wait for the pipe
  task automatic wait_block_idle();
    while (samples_accepted != samples_queued) @(posedge clk);
    while (expected_charges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(input int value, input bit last);
    in_item_t item;
    item.sample_value = value[SAMPLE_W-1:0];
    item.record_end   = last;
    pending_samples.insert(pending_samples.size(), item);
    samples_queued++;
  endtask

  function automatic int pick_sample(input sample_style_e style);
    case (style)
      STYLE_UNIFORM: return $urandom_range(0, SAMPLE_MAX);
      STYLE_RAILS:   return $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      STYLE_PULSE:   return $urandom_range(7980, 8020) - ($urandom_range(0, 5) == 0 ?
                            $urandom_range(0, 4000) : 0);
      default:       return $urandom & SAMPLE_MAX;
    endcase
  endfunction

  task automatic queue_record(input int len);
    sample_style_e style;
    style = sample_style_e'($urandom_range(0, 3));
    for (int k = 0; k < len; k++) push_sample(pick_sample(style), k == len - 1);
  endtask

  initial begin
    int random_items;
    int phase_items;
    int len;
    int lo;
    int unsigned bc;
    int unsigned gs;
    int unsigned gp;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Records at the reset settings: one runs into the gate, one stays in the window
    queue_record(410);
    queue_record(3);
    wait_block_idle();

    // Directed records on a tiny gate
    set_gate(2, 3, 6);
    push_sample(0, 0);
    push_sample(SAMPLE_MAX, 0);
    push_sample(SAMPLE_MAX, 0);
    push_sample(0, 0);
    push_sample(SAMPLE_MAX, 0);
    push_sample(8191, 1);
    // shorter than the baseline window
    push_sample(SAMPLE_MAX, 1);
    // ends inside the gate
    push_sample(5, 0);
    push_sample(5, 0);
    push_sample(5, 0);
    push_sample(SAMPLE_MAX, 1);
    // runs past the gate
    for (int k = 0; k < 8; k++) push_sample(k < 2 ? SAMPLE_MAX : (k == 7), k == 7);
    wait_block_idle();

    // Setting extremes: minimum window, invalid setups, empty gates
    set_gate(1, 1, 2);
    for (int k = 1; k <= 4; k++) queue_record(k);
    wait_block_idle();
    set_gate(1, 0, 3);
    queue_record(3);
    queue_record(5);
    wait_block_idle();
    set_gate(0, 4, 10);
    queue_record(10);
    queue_record(12);
    wait_block_idle();
    set_gate(16, 4095, 8191);
    queue_record(20);
    queue_record(40);
    wait_block_idle();
    set_gate(8, 8, 0);
    queue_record(12);
    queue_record(1);
    wait_block_idle();
    set_gate(6, 10, 10);
    queue_record(14);
    wait_block_idle();

    // Widest valid baseline window and one past it; empty gate leaves only the setup test
    set_gate(1024, 1024, 0);
    queue_record(5);
    wait_block_idle();
    set_gate(1025, 1025, 0);
    queue_record(5);
    wait_block_idle();

    // Random phases; the long result hold-off fires early in this part
    hold_at = samples_queued + 100;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items > RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
      bc = $urandom_range(1, 16);
      gs = bc + $urandom_range(0, 8);
      gp = gs + $urandom_range(1, 24);
      case ($urandom_range(0, 4))
        3: begin
          // invalid setup: zero window or gate opening inside the window
          if ($urandom_range(0, 1)) begin
            bc = 0;
            gs = $urandom_range(0, 8);
          end else begin
            bc = $urandom_range(2, 16);
            gs = $urandom_range(0, bc - 1);
          end
          gp = gs + $urandom_range(1, 24);
        end
        4: gp = $urandom_range(0, gs);
        default: ;
      endcase
      wait_block_idle();
      set_gate(bc, gs, gp);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          lo  = (gp > 2) ? gp - 2 : 1;
          len = $urandom_range(lo, gp + 6);
        end else begin
          len = $urandom_range(1, 8);
        end
        queue_record(len);
        phase_items += len;
      end
      random_items += phase_items;
    end

    wait_block_idle();
    $display("covered %0d samples, %0d records checked, %0d register settings",
             samples_accepted, records_checked, settings_count);
    $display("input held back by a full pipe on %0d cycles", stalled_offers);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pci_pkg.sv
hdl/pci_regs.sv
hdl/pulse_charge_integrator.sv
hdl/pci_checker.sv
test/pulse_charge_integrator_test.sv
